>>> rtl/cbts_pkg.sv
`timescale 1ns / 1ps

package cbts_pkg;

    localparam int SPEED_W      = 10;
    localparam int CLK_W        = 16;
    localparam int FIELD_W      = 4;
    localparam int ERR_W        = 10;
    localparam int MIN_QUANTA   = 4;
    localparam int PROP_SHIFT   = 3;
    localparam int SEG_CAP      = 16;

    localparam logic [CLK_W-1:0] BASE_CLOCK_RESET = 16'd8000;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture rate, prescaler back to one
        logic div_start;
        logic div_sel_clk;  // divide by prescaler alone, not prescaler * rate
        logic step;         // next prescaler
        logic take_q;
        logic finish;       // work out segments and error
        logic fail;
        logic out_load;
    } cbts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic speed_zero;
        logic div_done;
        logic q_fits;
        logic q_small;
        logic p_last;
    } cbts_sts_t;

endpackage

>>> rtl/cbts_div.sv
`timescale 1ns / 1ps

module cbts_div
    import cbts_pkg::*;
#(
    parameter int N_W = 16,
    parameter int D_W = 14
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dsr_reg, dsr_next;

    logic [D_W:0]     rem_shift;
    logic [D_W:0]     diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[N_W-1]};
        diff      = rem_shift - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(N_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[D_W])
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy_reg |-> ##(N_W + 1) done_reg)
        else $error("divider done not on time");

endmodule

>>> rtl/cbts_dp.sv
`timescale 1ns / 1ps

module cbts_dp
    import cbts_pkg::*;
#(
    parameter int MAX_QUANTA_PER_BIT = 25,
    parameter int MAX_PRESCALER      = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CLK_W-1:0]   cfg_data,
    input  logic [SPEED_W-1:0] speed_kbps,
    input  cbts_cmd_t          cmd,
    output cbts_sts_t          sts,
    output logic               ok,
    output logic [FIELD_W-1:0] prescaler,
    output logic [FIELD_W-1:0] prop_quanta,
    output logic [FIELD_W-1:0] phase1_quanta,
    output logic [FIELD_W-1:0] phase2_quanta,
    output logic [ERR_W-1:0]   rate_error
);

    localparam int P_W   = $clog2(MAX_PRESCALER + 1);
    localparam int D_W   = SPEED_W + P_W;
    localparam int Q_W   = $clog2(MAX_QUANTA_PER_BIT + 1);
    localparam int SEG_W = (Q_W > 5) ? Q_W : 5;
    localparam int PX_W  = (P_W > FIELD_W) ? P_W : FIELD_W;

    logic [CLK_W-1:0]   base_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [P_W-1:0]     p_reg;
    logic [D_W-1:0]     prod_reg;
    logic [Q_W-1:0]     q_reg;

    logic               res_ok_reg;
    logic [FIELD_W-1:0] res_presc_reg;
    logic [FIELD_W-1:0] res_prop_reg;
    logic [FIELD_W-1:0] res_ps_reg;
    logic [ERR_W-1:0]   res_err_reg;

    logic               ok_reg;
    logic [FIELD_W-1:0] presc_reg;
    logic [FIELD_W-1:0] prop_reg;
    logic [FIELD_W-1:0] ps1_reg;
    logic [FIELD_W-1:0] ps2_reg;
    logic [ERR_W-1:0]   err_reg;

    logic [D_W-1:0]     divisor;
    logic               div_done;
    logic [CLK_W-1:0]   div_quotient;
    logic [PX_W-1:0]    p_ext;
    logic [SEG_W-1:0]   seg_r;
    logic [SEG_W-1:0]   seg_prop;
    logic [SEG_W-1:0]   seg_ps;
    logic [CLK_W-1:0]   q_times_s;
    logic [CLK_W-1:0]   err_full;

    // q = floor(floor(base / p) / s) = floor(base / (p * s)); the product is
    // kept as a running sum of the rate
    assign divisor = cmd.div_sel_clk ? D_W'(p_reg) : prod_reg;

    cbts_div #(
        .N_W (CLK_W),
        .D_W (D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (base_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        sts.speed_zero = (speed_kbps == '0);
        sts.div_done   = div_done;
        sts.q_fits     = (div_quotient <= CLK_W'(MAX_QUANTA_PER_BIT));
        sts.q_small    = (div_quotient < CLK_W'(MIN_QUANTA));
        sts.p_last     = (p_reg == P_W'(MAX_PRESCALER));
    end

    // segment split: sync quantum off, eighth to propagation (at least one),
    // excess over the cap and any odd quantum to propagation too
    always_comb
    begin
        seg_r    = SEG_W'(q_reg) - 1'b1;
        seg_prop = seg_r >> PROP_SHIFT;
        if (seg_prop == '0)
            seg_prop = SEG_W'(1);
        seg_r = seg_r - seg_prop;
        if (seg_r > SEG_W'(SEG_CAP))
        begin
            seg_prop = seg_prop + (seg_r - SEG_W'(SEG_CAP));
            seg_r    = SEG_W'(SEG_CAP);
        end
        if (seg_r[0])
        begin
            seg_prop = seg_prop + 1'b1;
            seg_r    = seg_r - 1'b1;
        end
        seg_ps = seg_r >> 1;
    end

    // quotient now holds floor(base / p); remainder by rate without a divide
    assign q_times_s = CLK_W'(q_reg) * CLK_W'(speed_reg);
    assign err_full  = div_quotient - q_times_s;
    assign p_ext     = PX_W'(p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_CLOCK_RESET;
        else if (cfg_we)
            base_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            speed_reg <= speed_kbps;
            p_reg     <= P_W'(1);
            prod_reg  <= D_W'(speed_kbps);
        end
        else if (cmd.step)
        begin
            p_reg    <= p_reg + 1'b1;
            prod_reg <= prod_reg + D_W'(speed_reg);
        end

        if (cmd.take_q)
            q_reg <= div_quotient[Q_W-1:0];

        if (cmd.fail)
        begin
            res_ok_reg    <= 1'b0;
            res_presc_reg <= '0;
            res_prop_reg  <= '0;
            res_ps_reg    <= '0;
            res_err_reg   <= '0;
        end
        else if (cmd.finish)
        begin
            res_ok_reg    <= 1'b1;
            res_presc_reg <= p_ext[FIELD_W-1:0];
            res_prop_reg  <= seg_prop[FIELD_W-1:0];
            res_ps_reg    <= seg_ps[FIELD_W-1:0];
            res_err_reg   <= err_full[ERR_W-1:0];
        end

        if (cmd.out_load)
        begin
            ok_reg    <= res_ok_reg;
            presc_reg <= res_presc_reg;
            prop_reg  <= res_prop_reg;
            ps1_reg   <= res_ps_reg;
            ps2_reg   <= res_ps_reg;
            err_reg   <= res_err_reg;
        end
    end

    assign ok            = ok_reg;
    assign prescaler     = presc_reg;
    assign prop_quanta   = prop_reg;
    assign phase1_quanta = ps1_reg;
    assign phase2_quanta = ps2_reg;
    assign rate_error    = err_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> p_reg != P_W'(MAX_PRESCALER))
        else $error("prescaler stepped past its limit");

    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> q_times_s <= div_quotient)
        else $error("quanta times rate exceeds scaled clock");

endmodule

>>> rtl/cbts_ctrl.sv
`timescale 1ns / 1ps

module cbts_ctrl
    import cbts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  cbts_sts_t sts,
    output cbts_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_Q,
        S_WAIT_Q,
        S_WAIT_C,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.speed_zero)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_START_Q;
                    end
                end
            end
            S_START_Q:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_Q;
            end
            S_WAIT_Q:
            begin
                if (sts.div_done)
                begin
                    if (sts.q_fits)
                    begin
                        if (sts.q_small)
                        begin
                            cmd.fail   = 1'b1;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.take_q      = 1'b1;
                            cmd.div_start   = 1'b1;
                            cmd.div_sel_clk = 1'b1;
                            state_next      = S_WAIT_C;
                        end
                    end
                    else if (sts.p_last)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = S_START_Q;
                    end
                end
            end
            S_WAIT_C:
            begin
                if (sts.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // output register free or emptying this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("transfer accepted but no work started");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside result state");

endmodule

>>> rtl/can_bit_timing_select_core.sv
`timescale 1ns / 1ps

// CAN bit timing selection. A transfer on the input channel carries a bit rate
// in kbit/s; one result transfer follows with the smallest prescaler (1 up to
// MAX_PRESCALER) giving at most MAX_QUANTA_PER_BIT quanta per bit, the
// propagation and phase segment lengths, and the scaled clock remainder as
// rate error. A zero rate, no fitting prescaler or fewer than four quanta
// give ok low and all other fields zero. base_clock_khz (reset 8000) is
// written over the configuration channel; the user must write it only while
// the block is idle, which the block does not enforce. One iterative divider,
// one quotient bit per cycle, sets the pace: each prescaler tried costs a
// division of the base clock by prescaler times rate, then a division by the
// prescaler alone gives the error. One item is worked on at a time; the next
// is taken while the previous result still waits in the output register.
module can_bit_timing_select_core
    import cbts_pkg::*;
#(
    parameter int MAX_QUANTA_PER_BIT = 25,
    parameter int MAX_PRESCALER      = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CLK_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [SPEED_W-1:0] speed_kbps,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [FIELD_W-1:0] prescaler,
    output logic [FIELD_W-1:0] prop_quanta,
    output logic [FIELD_W-1:0] phase1_quanta,
    output logic [FIELD_W-1:0] phase2_quanta,
    output logic [ERR_W-1:0]   rate_error
);

    cbts_cmd_t cmd;
    cbts_sts_t sts;

    assign cfg_ready = 1'b1;

    cbts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cbts_dp #(
        .MAX_QUANTA_PER_BIT (MAX_QUANTA_PER_BIT),
        .MAX_PRESCALER      (MAX_PRESCALER)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .speed_kbps    (speed_kbps),
        .cmd           (cmd),
        .sts           (sts),
        .ok            (ok),
        .prescaler     (prescaler),
        .prop_quanta   (prop_quanta),
        .phase1_quanta (phase1_quanta),
        .phase2_quanta (phase2_quanta),
        .rate_error    (rate_error)
    );

endmodule
